// ----- rtl/kcl_pkg.sv -----
`default_nettype none

package kcl_pkg;

  localparam int unsigned CODE_LENGTH = 4;   // digits per entry, 1..4
  localparam int unsigned NUM_SLOTS   = 4;
  localparam int unsigned SLOT_W      = 2;
  localparam int unsigned DIGIT_W     = 3;
  localparam int unsigned BTN_W       = 4;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned PER_W       = 8;
  localparam int unsigned CODE_W      = DIGIT_W * NUM_SLOTS;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CODE_W-1:0] CODE_RST     = 12'd2257;
  localparam logic [CNT_W-1:0]  DEBOUNCE_RST = 16'd40;
  localparam logic [CNT_W-1:0]  TIMEOUT_RST  = 16'd5000;
  localparam logic [CNT_W-1:0]  BLINK_RST    = 16'd300;
  localparam logic [PER_W-1:0]  PERIODS_RST  = 8'd33;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CONFIRM,
    PH_HELD,
    PH_RELEASE
  } press_phase_e;

  typedef enum logic [1:0] {
    VERDICT_NONE,
    VERDICT_ACCEPT,
    VERDICT_REJECT
  } verdict_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CODE,
    CFG_DEBOUNCE,
    CFG_TIMEOUT,
    CFG_BLINK,
    CFG_PERIODS
  } cfg_idx_e;

  typedef struct packed {
    logic [CODE_W-1:0] code_digits;
    logic [CNT_W-1:0]  debounce_ticks;
    logic [CNT_W-1:0]  entry_timeout_ticks;
    logic [CNT_W-1:0]  blink_period_ticks;
    logic [PER_W-1:0]  open_periods;
  } cfg_t;

  // entry logic -> result register and door timer
  typedef struct packed {
    verdict_e          verdict;
    logic              open_req;
    logic [SLOT_W-1:0] entry_index;
  } entry_res_t;

endpackage

`default_nettype wire

// ----- rtl/keypad_code_lock_controller_top.sv -----
// Channel   Handshake                 Payload
// in        in_valid_i / in_ready_o   buttons_low_i
// out       out_valid_o / out_ready_i relay_open_o, led_on_o, digit_taken_o,
//                                     verdict_o, digits_entered_o
// cfg       cfg_we_i                  cfg_addr_i, cfg_wdata_i
//
// One item per cycle sustained while the output is not stalled; an accepted item
// passes through the input register and then the result register to the output.
// All per-tick state is updated in one pass from the input register.
// Reset clears the controller state and loads the default configuration.
// A stalled output holds its item; the input register keeps taking items
// whenever its content moves on in the same cycle.
`default_nettype none

module keypad_code_lock_controller_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [kcl_pkg::BTN_W-1:0]        buttons_low_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic                                  relay_open_o,
  output logic                                  led_on_o,
  output logic      [2:0]                       digit_taken_o,
  output logic      [1:0]                       verdict_o,
  output logic      [2:0]                       digits_entered_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [kcl_pkg::CFG_IDX_W-1:0]    cfg_addr_i,
  input  wire logic [kcl_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  kcl_pkg::cfg_t                 cfg_q;
  logic                          in_valid_q;
  logic [kcl_pkg::BTN_W-1:0]     buttons_q;
  logic                          step;
  logic                          door_open;
  logic [kcl_pkg::DIGIT_W-1:0]   digit;
  kcl_pkg::entry_res_t           entry_res;
  logic                          relay_d, led_d;

  logic                          out_valid_q;
  logic                          relay_q, led_q;
  logic [kcl_pkg::DIGIT_W-1:0]   digit_q;
  kcl_pkg::verdict_e             verdict_q;
  logic [kcl_pkg::SLOT_W-1:0]    entered_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.code_digits         <= kcl_pkg::CODE_RST;
      cfg_q.debounce_ticks      <= kcl_pkg::DEBOUNCE_RST;
      cfg_q.entry_timeout_ticks <= kcl_pkg::TIMEOUT_RST;
      cfg_q.blink_period_ticks  <= kcl_pkg::BLINK_RST;
      cfg_q.open_periods        <= kcl_pkg::PERIODS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        kcl_pkg::CFG_CODE:     cfg_q.code_digits <= cfg_wdata_i[kcl_pkg::CODE_W-1:0];
        kcl_pkg::CFG_DEBOUNCE: cfg_q.debounce_ticks <= cfg_wdata_i;
        kcl_pkg::CFG_TIMEOUT:  cfg_q.entry_timeout_ticks <= cfg_wdata_i;
        kcl_pkg::CFG_BLINK:    cfg_q.blink_period_ticks <= cfg_wdata_i;
        kcl_pkg::CFG_PERIODS:  cfg_q.open_periods <= cfg_wdata_i[kcl_pkg::PER_W-1:0];
        default: ;
      endcase
    end
  end

  // item moves from input register to result register
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) buttons_q <= buttons_low_i;
  end

  kcl_debounce u_debounce (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .hold_i           (door_open),
    .buttons_low_i    (buttons_q),
    .debounce_ticks_i (cfg_q.debounce_ticks),
    .digit_o          (digit)
  );

  kcl_entry u_entry (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .step_i                (step),
    .door_open_i           (door_open),
    .digit_i               (digit),
    .code_digits_i         (cfg_q.code_digits),
    .entry_timeout_ticks_i (cfg_q.entry_timeout_ticks),
    .res_o                 (entry_res)
  );

  kcl_door u_door (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .step_i               (step),
    .open_req_i           (entry_res.open_req),
    .blink_period_ticks_i (cfg_q.blink_period_ticks),
    .open_periods_i       (cfg_q.open_periods),
    .door_open_o          (door_open),
    .relay_open_o         (relay_d),
    .led_on_o             (led_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      relay_q   <= relay_d;
      led_q     <= led_d;
      digit_q   <= digit;
      verdict_q <= entry_res.verdict;
      entered_q <= entry_res.entry_index;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign relay_open_o     = relay_q;
  assign led_on_o         = led_q;
  assign digit_taken_o    = digit_q;
  assign verdict_o        = verdict_q;
  assign digits_entered_o = {1'b0, entered_q};

endmodule

`default_nettype wire

// ----- rtl/kcl_debounce.sv -----
`default_nettype none

module kcl_debounce (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           step_i,
  input  wire logic                           hold_i,
  input  wire logic [kcl_pkg::BTN_W-1:0]      buttons_low_i,
  input  wire logic [kcl_pkg::CNT_W-1:0]      debounce_ticks_i,
  output logic      [kcl_pkg::DIGIT_W-1:0]    digit_o
);

  kcl_pkg::press_phase_e            phase_q, phase_d;
  logic [kcl_pkg::DIGIT_W-1:0]      held_q, held_d;
  logic [kcl_pkg::CNT_W-1:0]        count_q, count_d;
  logic [kcl_pkg::BTN_W-1:0]        pressed;
  logic [1:0]                       held_idx;
  logic                             held_down;

  assign pressed   = ~buttons_low_i;
  assign held_idx  = held_q[1:0] - 2'd1;
  assign held_down = (held_q != '0) && (held_q <= 3'd4) && pressed[held_idx];

  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    count_d = count_q;
    digit_o = '0;
    if (hold_i) begin
      phase_d = kcl_pkg::PH_IDLE;
      held_d  = '0;
      count_d = '0;
    end else begin
      unique case (phase_q)
        kcl_pkg::PH_IDLE: begin
          // lowest-numbered button wins
          for (int k = kcl_pkg::BTN_W - 1; k >= 0; k--) begin
            if (pressed[k]) held_d = kcl_pkg::DIGIT_W'(k + 1);
          end
          if (pressed != '0) begin
            count_d = 16'd1;
            phase_d = (debounce_ticks_i <= 16'd1) ? kcl_pkg::PH_HELD : kcl_pkg::PH_CONFIRM;
          end
        end
        kcl_pkg::PH_CONFIRM: begin
          if (held_down) begin
            count_d = count_q + 16'd1;
            if (count_d >= debounce_ticks_i) phase_d = kcl_pkg::PH_HELD;
          end else begin
            phase_d = kcl_pkg::PH_IDLE;
            held_d  = '0;
            count_d = '0;
          end
        end
        kcl_pkg::PH_HELD: begin
          if (!held_down) begin
            count_d = 16'd1;
            phase_d = kcl_pkg::PH_RELEASE;
          end
        end
        kcl_pkg::PH_RELEASE: begin
          if (count_q != '1) count_d = count_q + 16'd1;
        end
        default: phase_d = kcl_pkg::PH_IDLE;
      endcase
      // release delay ends: the digit is taken now
      if (phase_d == kcl_pkg::PH_RELEASE && count_d >= debounce_ticks_i) begin
        digit_o = held_d;
        phase_d = kcl_pkg::PH_IDLE;
        held_d  = '0;
        count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= kcl_pkg::PH_IDLE;
      held_q  <= '0;
      count_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/kcl_entry.sv -----
`default_nettype none

module kcl_entry (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire logic                          door_open_i,
  input  wire logic [kcl_pkg::DIGIT_W-1:0]   digit_i,
  input  wire logic [kcl_pkg::CODE_W-1:0]    code_digits_i,
  input  wire logic [kcl_pkg::CNT_W-1:0]     entry_timeout_ticks_i,
  output kcl_pkg::entry_res_t                res_o
);

  logic [kcl_pkg::SLOT_W-1:0]  idx_q, idx_d, idx_mid;
  logic [kcl_pkg::CNT_W-1:0]   idle_q, idle_d;
  logic [kcl_pkg::DIGIT_W-1:0] slots_q [kcl_pkg::NUM_SLOTS];
  logic [kcl_pkg::SLOT_W:0]    idx_inc;
  logic                        match;
  logic                        slot_we;

  always_comb begin
    idx_d          = idx_q;
    idle_d         = idle_q;
    idx_mid        = idx_q;
    idx_inc        = '0;
    match          = 1'b1;
    slot_we        = 1'b0;
    res_o.verdict  = kcl_pkg::VERDICT_NONE;
    res_o.open_req = 1'b0;
    if (!door_open_i) begin
      // timeout is checked before a digit of the same tick
      if (idx_q != '0) begin
        if (idle_q != '1) idle_d = idle_q + 16'd1;
        if (idle_d > entry_timeout_ticks_i) begin
          idx_mid = '0;
          idle_d  = '0;
        end
      end
      idx_d = idx_mid;
      if (digit_i != '0) begin
        idle_d  = '0;
        slot_we = 1'b1;
        idx_inc = {1'b0, idx_mid} + 3'd1;
        idx_d   = idx_inc[kcl_pkg::SLOT_W-1:0];
        if (idx_inc >= (kcl_pkg::SLOT_W+1)'(kcl_pkg::CODE_LENGTH)) begin
          for (int i = 0; i < kcl_pkg::CODE_LENGTH; i++) begin
            if (((kcl_pkg::SLOT_W'(i) == idx_mid) ? digit_i : slots_q[i]) !=
                code_digits_i[kcl_pkg::DIGIT_W*i +: kcl_pkg::DIGIT_W]) begin
              match = 1'b0;
            end
          end
          idx_d = '0;
          if (match) begin
            res_o.verdict  = kcl_pkg::VERDICT_ACCEPT;
            res_o.open_req = 1'b1;
          end else begin
            res_o.verdict  = kcl_pkg::VERDICT_REJECT;
          end
        end
      end
    end
    res_o.entry_index = idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      idle_q <= '0;
    end else if (step_i) begin
      idx_q  <= idx_d;
      idle_q <= idle_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && slot_we) begin
      slots_q[idx_mid] <= digit_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/kcl_door.sv -----
`default_nettype none

module kcl_door (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        step_i,
  input  wire logic                        open_req_i,
  input  wire logic [kcl_pkg::CNT_W-1:0]   blink_period_ticks_i,
  input  wire logic [kcl_pkg::PER_W-1:0]   open_periods_i,
  output logic                             door_open_o,
  output logic                             relay_open_o,
  output logic                             led_on_o
);

  logic                        open_q, open_d;
  logic [kcl_pkg::PER_W-1:0]   pidx_q, pidx_d;
  logic [kcl_pkg::CNT_W-1:0]   pticks_q, pticks_d;
  logic [kcl_pkg::CNT_W:0]     pticks_inc;

  assign pticks_inc = {1'b0, pticks_q} + 17'd1;

  always_comb begin
    open_d   = open_q;
    pidx_d   = pidx_q;
    pticks_d = pticks_q;
    if (open_q) begin
      if (pticks_inc >= {1'b0, blink_period_ticks_i}) begin
        pticks_d = '0;
        pidx_d   = pidx_q + 8'd1;
        if (pidx_d >= open_periods_i) begin
          open_d = 1'b0;
          pidx_d = '0;
        end
      end else begin
        pticks_d = pticks_inc[kcl_pkg::CNT_W-1:0];
      end
    end else if (open_req_i) begin
      open_d   = 1'b1;
      pidx_d   = '0;
      pticks_d = '0;
    end
  end

  assign door_open_o  = open_q;
  assign relay_open_o = open_d;
  assign led_on_o     = open_d ? pidx_d[0] : 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q   <= 1'b0;
      pidx_q   <= '0;
      pticks_q <= '0;
    end else if (step_i) begin
      open_q   <= open_d;
      pidx_q   <= pidx_d;
      pticks_q <= pticks_d;
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/keypad_code_lock_controller_top_test.sv -----
module keypad_code_lock_controller_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import kcl_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned HOLD_OFF     = 60;
  localparam int unsigned MAX_REPORTED = 10;

  typedef struct packed {
    logic       relay;
    logic       led;
    logic [2:0] digit;
    verdict_e   verdict;
    logic [2:0] entered;
  } lock_result_t;

  // Tracks the lock per tick and holds the outputs each accepted tick should produce
  class lock_tracker;
    logic [CODE_W-1:0] code_digits;
    logic [CNT_W-1:0]  debounce;
    logic [CNT_W-1:0]  timeout;
    logic [CNT_W-1:0]  blink;
    logic [PER_W-1:0]  periods;

    press_phase_e      phase;
    logic [2:0]        held;
    logic [CNT_W-1:0]  stable;
    logic [2:0]        digits [NUM_SLOTS];
    logic [2:0]        n_entered;
    logic [CNT_W-1:0]  idle;
    bit                door_open;
    logic [PER_W-1:0]  period_idx;
    logic [CNT_W-1:0]  period_ticks;

    lock_result_t      expected_outputs [$];
    int unsigned       errors, checked;
    int unsigned       digit_count, opened, rejected, discarded;

    function new();
      code_digits  = CODE_RST;
      debounce     = DEBOUNCE_RST;
      timeout      = TIMEOUT_RST;
      blink        = BLINK_RST;
      periods      = PERIODS_RST;
      phase        = PH_IDLE;
      held         = '0;
      stable       = '0;
      foreach (digits[i]) digits[i] = '0;
      n_entered    = '0;
      idle         = '0;
      door_open    = 1'b0;
      period_idx   = '0;
      period_ticks = '0;
    endfunction

    function void write_cfg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CODE:     code_digits = data[CODE_W-1:0];
        CFG_DEBOUNCE: debounce    = data;
        CFG_TIMEOUT:  timeout     = data;
        CFG_BLINK:    blink       = data;
        CFG_PERIODS:  periods     = data[PER_W-1:0];
        default: ;
      endcase
    endfunction

    function bit is_down(logic [BTN_W-1:0] b, logic [2:0] n);
      return (n >= 1 && n <= 4) && !b[n - 1];
    endfunction

    function logic [2:0] debounce_tick(logic [BTN_W-1:0] b);
      logic [2:0] dig;
      dig = '0;
      case (phase)
        PH_IDLE: begin
          // lowest-numbered pressed button wins
          for (int k = 3; k >= 0; k--) if (!b[k]) held = 3'(k + 1);
          if (b != 4'hF) begin
            stable = 1;
            phase  = (stable >= debounce) ? PH_HELD : PH_CONFIRM;
          end
        end
        PH_CONFIRM: begin
          if (is_down(b, held)) begin
            stable++;
            if (stable >= debounce) phase = PH_HELD;
          end else begin
            phase  = PH_IDLE;
            stable = '0;
            held   = '0;
          end
        end
        PH_HELD: begin
          if (!is_down(b, held)) begin
            stable = 1;
            phase  = PH_RELEASE;
          end
        end
        default: begin
          if (stable != 16'hFFFF) stable++;
        end
      endcase
      if (phase == PH_RELEASE && stable >= debounce) begin
        dig    = held;
        phase  = PH_IDLE;
        stable = '0;
        held   = '0;
      end
      return dig;
    endfunction

    function void note_buttons(logic [BTN_W-1:0] b);
      lock_result_t want;
      logic [2:0]   dig;
      verdict_e     verdict;
      bit           match;
      dig     = '0;
      verdict = VERDICT_NONE;
      if (door_open) begin
        phase  = PH_IDLE;
        held   = '0;
        stable = '0;
        period_ticks++;
        if (period_ticks >= blink) begin
          period_ticks = '0;
          period_idx++;
          if (period_idx >= periods) begin
            door_open  = 1'b0;
            period_idx = '0;
          end
        end
      end else begin
        dig = debounce_tick(b);
        // timeout is judged before a digit of the same tick
        if (n_entered > 0) begin
          if (idle != 16'hFFFF) idle++;
          if (idle > timeout) begin
            n_entered = '0;
            idle      = '0;
            discarded++;
          end
        end
        if (dig != 0) begin
          digit_count++;
          idle = '0;
          digits[n_entered[1:0]] = dig;
          n_entered++;
          if (n_entered >= CODE_LENGTH) begin
            match = 1'b1;
            for (int i = 0; i < CODE_LENGTH; i++)
              if (digits[i] != code_digits[3*i +: 3]) match = 1'b0;
            n_entered = '0;
            if (match) begin
              verdict      = VERDICT_ACCEPT;
              door_open    = 1'b1;
              period_idx   = '0;
              period_ticks = '0;
              opened++;
            end else begin
              verdict = VERDICT_REJECT;
              rejected++;
            end
          end
        end
      end
      want.relay   = door_open;
      want.led     = door_open ? period_idx[0] : 1'b1;
      want.digit   = dig;
      want.verdict = verdict;
      want.entered = n_entered;
      expected_outputs.push_back(want);
    endfunction

    function void check_outputs(lock_result_t got);
      lock_result_t want;
      checked++;
      if (expected_outputs.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTED)
          $display("unexpected result: relay %0b led %0b digit %0d verdict %0d entered %0d",
                   got.relay, got.led, got.digit, got.verdict, got.entered);
        return;
      end
      want = expected_outputs.pop_front();
      if (got.relay !== want.relay || got.led !== want.led || got.digit !== want.digit ||
          got.verdict !== want.verdict || got.entered !== want.entered) begin
        errors++;
        if (errors <= MAX_REPORTED) begin
          $display("result %0d differs: expected relay %0b led %0b digit %0d verdict %0d",
                   checked, want.relay, want.led, want.digit, want.verdict);
          $display("  expected entered %0d, got relay %0b led %0b digit %0d",
                   want.entered, got.relay, got.led, got.digit);
          $display("  got verdict %0d entered %0d", got.verdict, got.entered);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_outputs.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_ready_o;
  logic [BTN_W-1:0]      buttons_low_i = 4'hF;
  logic                  out_valid_o;
  logic                  out_ready_i   = 1'b0;
  logic                  relay_open_o;
  logic                  led_on_o;
  logic [2:0]            digit_taken_o;
  logic [1:0]            verdict_o;
  logic [2:0]            digits_entered_o;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;

  lock_tracker tracker = new();

  int unsigned cycle_count  = 0;
  int unsigned burst_left   = 0;
  int unsigned live_items   = 0;
  int unsigned total_items  = 0;
  int unsigned cfg_phases   = 0;
  int unsigned hold_offs    = 0;
  bit          hold_off_req = 1'b0;

  // all pressed, buttons 2 to 4 alone (completing the default code), then a wrong code and a timed-out entry
  logic [3:0] directed_seq [0:22] = '{
    4'h0, 4'hF, 4'hD, 4'hF, 4'hB, 4'hF, 4'h7, 4'hF, 4'h0,
    4'hE, 4'hF, 4'hE, 4'hF, 4'hE, 4'hF, 4'hE, 4'hF,
    4'h7, 4'hF, 4'hF, 4'hF, 4'hF, 4'hF
  };

  keypad_code_lock_controller_top dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("cycle limit of %0d reached with %0d results outstanding",
             CYCLE_LIMIT, tracker.pending());
    $display("keypad_code_lock_controller_top: mismatch");
    $finish;
  end

  // outputs sampled mid-cycle, the transfer happens at the next rising edge
  always @(negedge clk_i) begin
    lock_result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.relay   = relay_open_o;
      got.led     = led_on_o;
      got.digit   = digit_taken_o;
      got.verdict = verdict_e'(verdict_o);
      got.entered = digits_entered_o;
      tracker.check_outputs(got);
    end
  end

  initial begin : receiver
    int unsigned tick;
    tick = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk_i);
        hold_off_req = 1'b0;
        hold_offs++;
      end else begin
        case ((tick / 97) % 3)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= ($urandom_range(0, 3) != 0);
          default: out_ready_i <= ((tick % 7) > 2);
        endcase
      end
    end
  end

  function automatic logic [3:0] lower_mask(logic [2:0] dig);
    return 4'((1 << (dig - 1)) - 1);
  endfunction

  task automatic send_item(input logic [3:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    buttons_low_i <= b;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    if (!tracker.door_open) live_items++;
    total_items++;
    tracker.note_buttons(b);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= data;
    tracker.write_cfg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic apply_cfg(input logic [CODE_W-1:0] code, input logic [CNT_W-1:0] deb,
                           input logic [CNT_W-1:0] tmo, input logic [CNT_W-1:0] blink,
                           input logic [PER_W-1:0] per);
    write_reg(CFG_CODE, CFG_DATA_W'(code));
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_BLINK, blink);
    write_reg(CFG_PERIODS, CFG_DATA_W'(per));
    cfg_we_i <= 1'b0;
    cfg_phases++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // press, hold past the debounce time, release and sit out the release delay
  task automatic enter_digit(input logic [2:0] dig);
    int unsigned deb, hold, rel;
    logic [3:0]  b;
    deb  = (tracker.debounce == 0) ? 1 : tracker.debounce;
    hold = deb + $urandom_range(0, 3);
    rel  = deb + $urandom_range(0, 2);
    for (int t = 0; t < hold; t++) begin
      b = 4'($urandom);
      if (t == 0) b = b | lower_mask(dig);
      b[dig - 1] = 1'b0;
      send_item(b);
    end
    for (int t = 0; t < rel; t++) begin
      b = (t < deb) ? 4'($urandom) : 4'hF;
      if (t == 0) b[dig - 1] = 1'b1;
      send_item(b);
    end
  endtask

  task automatic try_code(input bit correct);
    logic [2:0]  dig;
    int unsigned gap;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      dig = tracker.code_digits[3*i +: 3];
      if (!correct || dig == 0 || dig > 4) dig = 3'($urandom_range(1, 4));
      enter_digit(dig);
      if ($urandom_range(0, 7) == 0 && tracker.timeout < 60)
        gap = tracker.timeout + $urandom_range(1, 3);
      else
        gap = $urandom_range(0, 2);
      repeat (gap) send_item(4'hF);
    end
    // buttons are ignored while open
    while (tracker.door_open) send_item(4'($urandom));
  endtask

  task automatic random_phase(input int unsigned target);
    int unsigned start_count, n;
    logic [2:0]  dig;
    logic [3:0]  b;
    start_count = live_items;
    while (live_items - start_count < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: try_code($urandom_range(0, 1));
        6, 7: begin
          // press let go before it is confirmed
          dig = 3'($urandom_range(1, 4));
          n = (tracker.debounce > 1) ? $urandom_range(1, tracker.debounce - 1) : 0;
          for (int t = 0; t < n; t++) begin
            b = 4'($urandom);
            if (t == 0) b = b | lower_mask(dig);
            b[dig - 1] = 1'b0;
            send_item(b);
          end
          send_item(4'hF);
        end
        8: begin
          n = $urandom_range(1, 8);
          repeat (n) send_item(4'($urandom));
        end
        default: begin
          enter_digit(3'($urandom_range(1, 4)));
          n = (tracker.timeout < 60) ? tracker.timeout + 2 : 3;
          repeat (n) send_item(4'hF);
        end
      endcase
    end
  endtask

  initial begin : stimulus
    logic [CODE_W-1:0] code;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration: one digit at the default debounce time
    enter_digit(3'd3);
    repeat (3) send_item(4'hF);

    settle();
    apply_cfg(CODE_RST, 16'd0, 16'd3, 16'd0, 8'd0);
    foreach (directed_seq[i]) send_item(directed_seq[i]);

    for (int p = 0; p < 6; p++) begin
      settle();
      code = CODE_W'($urandom);
      if ($urandom_range(0, 4) != 0)
        for (int i = 0; i < NUM_SLOTS; i++) code[3*i +: 3] = 3'($urandom_range(1, 4));
      apply_cfg(code, 16'($urandom_range(1, 4)), 16'($urandom_range(1, 30)),
                16'($urandom_range(1, 3)), 8'($urandom_range(1, 4)));
      if (p == 1) hold_off_req = 1'b1;
      random_phase(15);
    end

    // widest settings: nothing can confirm or time out here
    settle();
    apply_cfg(12'hFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    repeat (30) send_item(4'($urandom));

    // longest open stretch, entries never time out
    settle();
    for (int i = 0; i < NUM_SLOTS; i++) code[3*i +: 3] = 3'($urandom_range(1, 4));
    apply_cfg(code, 16'd1, 16'hFFFF, 16'd1, 8'd255);
    try_code(1'b1);
    try_code(1'b0);

    // code that can never match
    settle();
    apply_cfg(12'd0, 16'd1, 16'd20, 16'd2, 8'd1);
    random_phase(40);

    // shortest timeout
    settle();
    for (int i = 0; i < NUM_SLOTS; i++) code[3*i +: 3] = 3'($urandom_range(1, 4));
    apply_cfg(code, 16'd1, 16'd1, 16'd2, 8'd3);
    random_phase(30);

    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("%0d ticks (%0d while locked) over %0d settings, %0d long output stalls",
             total_items, live_items, cfg_phases, hold_offs);
    $display("%0d digits, %0d opened, %0d rejected, %0d entries timed out, %0d results checked",
             tracker.digit_count, tracker.opened, tracker.rejected, tracker.discarded,
             tracker.checked);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("keypad_code_lock_controller_top: match");
    else
      $display("keypad_code_lock_controller_top: mismatch");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/kcl_pkg.sv
rtl/kcl_debounce.sv
rtl/kcl_entry.sv
rtl/kcl_door.sv
rtl/keypad_code_lock_controller_top.sv
tb/sv/keypad_code_lock_controller_top_test.sv
